// ===== design/embedding_stats_pooling_macros.svh =====
// ---------------------------------------------------------------------------
// embedding_stats_pooling_macros
// assertion shorthands shared by the pooling block
// ---------------------------------------------------------------------------
`ifndef EMBEDDING_STATS_POOLING_MACROS_SVH
`define EMBEDDING_STATS_POOLING_MACROS_SVH

// same-cycle implication under the block reset
`define ESP_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication under the block reset
`define ESP_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== design/esp_pkg.sv =====
// ---------------------------------------------------------------------------
// esp_pkg
// types and fixed widths of the statistics pooling block
// ---------------------------------------------------------------------------
package esp_pkg;

	localparam int VALUE_BITS = 24;
	localparam int STD_BITS   = 23;
	localparam int INDEX_BITS = 11;
	localparam int DIM_BITS   = 12;
	localparam int OP_BITS    = 2;
	localparam int SUM_BITS   = 32;
	localparam int SQ_BITS    = 56;
	localparam int PROD_BITS  = 48;
	localparam int SEEN_BITS  = 8;

	localparam logic [DIM_BITS-1:0] DIM_RESET = 12'd521;

	typedef enum logic [OP_BITS-1:0] {
		OP_ACC   = 2'd0,
		OP_READ  = 2'd1,
		OP_CLEAR = 2'd2
	} op_t;

	typedef struct packed {
		op_t                          kind;
		logic [INDEX_BITS-1:0]        idx;
		logic signed [VALUE_BITS-1:0] value;
		logic [PROD_BITS-1:0]         square;
		logic                         eow;
		logic                         in_range;
	} entry_t;

	typedef struct packed {
		logic full;
		logic empty;
	} q_stat_t;

endpackage

// ===== design/esp_channels.sv =====
// ---------------------------------------------------------------------------
// esp_channels
// valid/ready channels of the statistics pooling block
// ---------------------------------------------------------------------------
interface esp_item_if;
	logic                                  valid;
	logic                                  ready;
	logic [esp_pkg::OP_BITS-1:0]           op;
	logic [esp_pkg::INDEX_BITS-1:0]        feat_index;
	logic signed [esp_pkg::VALUE_BITS-1:0] feat_value;
	logic                                  end_of_window;

	modport source(output valid, op, feat_index, feat_value, end_of_window, input ready);
	modport sink(input valid, op, feat_index, feat_value, end_of_window, output ready);
endinterface

interface esp_cfg_if;
	logic                         valid;
	logic                         ready;
	logic [esp_pkg::DIM_BITS-1:0] used_features;

	modport source(output valid, used_features, input ready);
	modport sink(input valid, used_features, output ready);
endinterface

interface esp_result_if;
	logic                                  valid;
	logic                                  ready;
	logic signed [esp_pkg::VALUE_BITS-1:0] mean_value;
	logic [esp_pkg::STD_BITS-1:0]          std_value;
	logic signed [esp_pkg::VALUE_BITS-1:0] max_value;
	logic [esp_pkg::SEEN_BITS-1:0]         windows_seen;
	logic                                  stats_valid;
	logic                                  count_overflow;

	modport source(output valid, mean_value, std_value, max_value, windows_seen,
		stats_valid, count_overflow, input ready);
	modport sink(input valid, mean_value, std_value, max_value, windows_seen,
		stats_valid, count_overflow, output ready);
endinterface

// ===== design/embedding_stats_pooling.sv =====
// Statistics pooling: per-feature mean, standard deviation and maximum of
// signed Q8.16 embedding values over a run of windows. The front takes one
// word per cycle, while the queue is not full, into a two-entry queue; the
// back end works one word at a time. An accumulate at a live index does a
// read-modify-write on the single-port sum, square-sum and max stores;
// clear and dropped accumulates leave the stores alone, and an unused op is
// taken and dropped at the front. A valid read runs a restoring divide of
// the square sum by the window count (the sum divide runs alongside), a
// 32x32 multiply, then a square root, and waits for the result word to be
// taken. An invalid read goes straight to the result word. Stores need no
// clearing after reset.
module embedding_stats_pooling #(
	parameter int MAX_FEATURES = 2048,
	parameter int MAX_WINDOWS  = 255
) (
	input  logic          clk,
	input  logic          arst_n,
	esp_cfg_if.sink       cfg,
	esp_item_if.sink      items,
	esp_result_if.source  results
);
	`include "embedding_stats_pooling_macros.svh"

	logic [esp_pkg::DIM_BITS-1:0] used_features_q;
	esp_pkg::q_stat_t             q_stat;
	esp_pkg::entry_t              push_entry;
	esp_pkg::entry_t              head;
	logic                         push;
	logic                         pop;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_features_q <= esp_pkg::DIM_RESET;
		end else if (cfg.valid) begin
			used_features_q <= cfg.used_features;
		end
	end

	esp_front #(.MAX_FEATURES(MAX_FEATURES)) u_front (
		.items         (items),
		.used_features (used_features_q),
		.q_stat        (q_stat),
		.push          (push),
		.entry         (push_entry)
	);

	esp_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.pop        (pop),
		.head       (head),
		.q_stat     (q_stat)
	);

	esp_back #(.MAX_FEATURES(MAX_FEATURES), .MAX_WINDOWS(MAX_WINDOWS)) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.q_stat  (q_stat),
		.pop     (pop),
		.results (results)
	);

	`ESP_ASSERT_NOW(a_no_pop_empty, pop, !q_stat.empty, "pop from empty queue")
	`ESP_ASSERT_NOW(a_full_stalls, q_stat.full, !items.ready && !push, "word taken into full queue")
	`ESP_ASSERT_NOW(a_invalid_zero, results.valid && !results.stats_valid, (results.mean_value == '0) && (results.std_value == '0) && (results.max_value == '0), "invalid read carries statistics")
	`ESP_ASSERT_NEXT(a_push_fills, push && !pop, !q_stat.empty, "queue empty after push")
endmodule

// ===== design/esp_front.sv =====
// ---------------------------------------------------------------------------
// esp_front
// accepts input words, decodes the op, checks the index and squares the value
// ---------------------------------------------------------------------------
module esp_front #(
	parameter int MAX_FEATURES = 2048
) (
	esp_item_if.sink                      items,
	input  logic [esp_pkg::DIM_BITS-1:0]  used_features,
	input  esp_pkg::q_stat_t              q_stat,
	output logic                          push,
	output esp_pkg::entry_t               entry
);
	localparam int LIM_BITS = esp_pkg::DIM_BITS + 1;
	localparam logic [LIM_BITS-1:0] FEAT_LIMIT = LIM_BITS'(MAX_FEATURES);

	logic [LIM_BITS-1:0]                      idx_ext;
	logic signed [2*esp_pkg::VALUE_BITS-1:0]  prod;

	assign items.ready = !q_stat.full;
	assign idx_ext = LIM_BITS'(items.feat_index);
	assign prod = items.feat_value * items.feat_value;

	always_comb begin
		entry.kind     = esp_pkg::OP_ACC;
		entry.idx      = items.feat_index;
		entry.value    = items.feat_value;
		entry.square   = prod[esp_pkg::PROD_BITS-1:0];
		entry.eow      = items.end_of_window;
		entry.in_range = (idx_ext < LIM_BITS'(used_features)) && (idx_ext < FEAT_LIMIT);
		push           = 1'b0;
		unique case (items.op)
			esp_pkg::OP_ACC: begin
				entry.kind = esp_pkg::OP_ACC;
				push       = items.valid && items.ready;
			end
			esp_pkg::OP_READ: begin
				entry.kind = esp_pkg::OP_READ;
				push       = items.valid && items.ready;
			end
			esp_pkg::OP_CLEAR: begin
				entry.kind = esp_pkg::OP_CLEAR;
				push       = items.valid && items.ready;
			end
			// unused op is taken and dropped
			default: push = 1'b0;
		endcase
	end
endmodule

// ===== design/esp_queue.sv =====
// ---------------------------------------------------------------------------
// esp_queue
// two-entry queue between the decode front and the execution back end
// ---------------------------------------------------------------------------
module esp_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  esp_pkg::entry_t  push_entry,
	input  logic             pop,
	output esp_pkg::entry_t  head,
	output esp_pkg::q_stat_t q_stat
);
	esp_pkg::entry_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      fill_q;

	assign q_stat.full  = (fill_q == 2'd2);
	assign q_stat.empty = (fill_q == 2'd0);
	assign head = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end
endmodule

// ===== design/esp_div.sv =====
// ---------------------------------------------------------------------------
// esp_div
// unsigned restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module esp_div #(
	parameter int W  = 32,
	parameter int DW = 8
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic [W-1:0]  dividend,
	input  logic [DW-1:0] divisor,
	output logic          done,
	output logic [W-1:0]  quotient
);
	localparam int CNT_BITS = $clog2(W + 1);

	logic [W-1:0]        qd_q;
	logic [DW-1:0]       rem_q;
	logic [DW-1:0]       d_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [DW:0]         trial;
	logic [DW:0]         diff;
	logic                ge;

	assign trial = {rem_q, qd_q[W-1]};
	assign diff  = trial - {1'b0, d_q};
	assign ge    = (trial >= {1'b0, d_q});
	assign done  = done_q;
	// dividend bits shift out at the top as quotient bits shift in
	assign quotient = qd_q;

	always_ff @(posedge clk) begin
		if (start) begin
			qd_q  <= dividend;
			rem_q <= '0;
			d_q   <= divisor;
		end else if (cnt_q != '0) begin
			qd_q  <= {qd_q[W-2:0], ge};
			rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(W);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_BITS'(1));
		end
	end
endmodule

// ===== design/esp_sqrt.sv =====
// ---------------------------------------------------------------------------
// esp_sqrt
// integer square root, one result bit per cycle
// ---------------------------------------------------------------------------
module esp_sqrt #(
	parameter int W = 56
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [W-1:0]   radicand,
	output logic           done,
	output logic [W/2-1:0] root
);
	localparam int CNT_BITS = $clog2(W / 2 + 1);

	logic [W-1:0]        x_q;
	logic [W-1:0]        res_q;
	logic [W-1:0]        bit_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                done_q;
	logic [W:0]          trial;
	logic                take;

	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = ({1'b0, x_q} >= trial);
	assign done  = done_q;
	assign root  = res_q[W/2-1:0];

	always_ff @(posedge clk) begin
		if (start) begin
			x_q   <= radicand;
			res_q <= '0;
			bit_q <= {2'b01, {(W-2){1'b0}}};
		end else if (cnt_q != '0) begin
			if (take) begin
				x_q   <= x_q - trial[W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_BITS'(W / 2);
			done_q <= 1'b0;
		end else if (cnt_q != '0) begin
			cnt_q  <= cnt_q - 1'b1;
			done_q <= (cnt_q == CNT_BITS'(1));
		end
	end
endmodule

// ===== design/esp_back.sv =====
// ---------------------------------------------------------------------------
// esp_back
// executes queued words: store updates, window count and statistics reads
// ---------------------------------------------------------------------------
module esp_back #(
	parameter int MAX_FEATURES = 2048,
	parameter int MAX_WINDOWS  = 255
) (
	input  logic             clk,
	input  logic             arst_n,
	input  esp_pkg::entry_t  head,
	input  esp_pkg::q_stat_t q_stat,
	output logic             pop,
	esp_result_if.source     results
);
	localparam int VB   = esp_pkg::VALUE_BITS;
	localparam int SB   = esp_pkg::SUM_BITS;
	localparam int QB   = esp_pkg::SQ_BITS;
	localparam int STB  = esp_pkg::STD_BITS;
	localparam int AW   = $clog2(MAX_FEATURES);
	localparam int CW   = $clog2(MAX_WINDOWS + 1);
	localparam int RB   = QB / 2;
	localparam logic [CW-1:0] WIN_LIMIT = CW'(MAX_WINDOWS);
	localparam logic [SB-1:0] POS_LIMIT = SB'((1 << (VB - 1)) - 1);
	localparam logic [SB-1:0] NEG_LIMIT = SB'(1 << (VB - 1));
	localparam logic [RB-1:0] STD_LIMIT = RB'((1 << STB) - 1);

	typedef enum logic [7:0] {
		S_IDLE = 8'b00000001,
		S_ACC  = 8'b00000010,
		S_LOAD = 8'b00000100,
		S_DIV  = 8'b00001000,
		S_MUL  = 8'b00010000,
		S_VAR  = 8'b00100000,
		S_SQRT = 8'b01000000,
		S_OUT  = 8'b10000000
	} state_t;

	state_t state_q;

	logic [SB-1:0]        sum_mem [MAX_FEATURES];
	logic [QB-1:0]        sq_mem  [MAX_FEATURES];
	logic signed [VB-1:0] max_mem [MAX_FEATURES];

	logic [SB-1:0]        sum_rd_q;
	logic [QB-1:0]        sq_rd_q;
	logic signed [VB-1:0] max_rd_q;

	logic [AW-1:0]        addr_q;
	logic signed [VB-1:0] value_q;
	logic [esp_pkg::PROD_BITS-1:0] square_q;
	logic                 eow_q;

	logic [CW-1:0]        count_q;
	logic                 ovf_q;
	logic                 neg_q;
	logic [2*SB-1:0]      m2_q;

	logic signed [VB-1:0]            res_mean_q;
	logic [STB-1:0]                  res_std_q;
	logic signed [VB-1:0]            res_max_q;
	logic [esp_pkg::SEEN_BITS-1:0]   res_seen_q;
	logic                            res_valid_q;
	logic                            res_ovf_q;

	logic                 wr_en;
	logic                 first;
	logic                 active;
	logic [SB-1:0]        new_sum;
	logic [QB-1:0]        new_sq;
	logic signed [VB-1:0] new_max;
	logic                 div_start;
	logic [SB-1:0]        sum_abs;
	logic                 qs_done;
	logic                 qe_done;
	logic [SB-1:0]        qs;
	logic [QB-1:0]        qe;
	logic                 sqrt_start;
	logic                 sqrt_done;
	logic [RB-1:0]        root;
	logic [QB-1:0]        var_val;
	logic [2*SB-1:0]      e2_ext;
	logic signed [VB-1:0] mean_sat;

	assign pop    = (state_q == S_IDLE) && !q_stat.empty;
	assign first  = (count_q == '0);
	assign active = (count_q != WIN_LIMIT) && head.in_range;
	assign wr_en  = (state_q == S_ACC);

	// first window overwrites, later windows accumulate
	always_comb begin
		new_sum = {{(SB-VB){value_q[VB-1]}}, value_q};
		new_sq  = QB'(square_q);
		new_max = value_q;
		if (!first) begin
			new_sum = sum_rd_q + {{(SB-VB){value_q[VB-1]}}, value_q};
			new_sq  = sq_rd_q + QB'(square_q);
			new_max = (value_q > max_rd_q) ? value_q : max_rd_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			sum_rd_q <= sum_mem[AW'(head.idx)];
			sq_rd_q  <= sq_mem[AW'(head.idx)];
			max_rd_q <= max_mem[AW'(head.idx)];
		end
		if (wr_en) begin
			sum_mem[addr_q] <= new_sum;
			sq_mem[addr_q]  <= new_sq;
			max_mem[addr_q] <= new_max;
		end
	end

	assign div_start = (state_q == S_LOAD);
	assign sum_abs   = sum_rd_q[SB-1] ? (~sum_rd_q + 1'b1) : sum_rd_q;

	esp_div #(.W(SB), .DW(CW)) u_div_sum (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum_abs),
		.divisor  (count_q),
		.done     (qs_done),
		.quotient (qs)
	);

	esp_div #(.W(QB), .DW(CW)) u_div_sq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sq_rd_q),
		.divisor  (count_q),
		.done     (qe_done),
		.quotient (qe)
	);

	// variance clamped at zero
	assign e2_ext     = (2*SB)'(qe);
	assign var_val    = (e2_ext > m2_q) ? QB'(e2_ext - m2_q) : '0;
	assign sqrt_start = (state_q == S_VAR);

	esp_sqrt #(.W(QB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (var_val),
		.done     (sqrt_done),
		.root     (root)
	);

	always_comb begin
		if (neg_q) begin
			mean_sat = (qs > NEG_LIMIT) ? NEG_LIMIT[VB-1:0] : -qs[VB-1:0];
		end else begin
			mean_sat = (qs > POS_LIMIT) ? POS_LIMIT[VB-1:0] : qs[VB-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			addr_q   <= AW'(head.idx);
			value_q  <= head.value;
			square_q <= head.square;
			eow_q    <= head.eow;
		end
		if (pop && (head.kind == esp_pkg::OP_READ)) begin
			res_seen_q <= esp_pkg::SEEN_BITS'(count_q);
			res_ovf_q  <= ovf_q;
			res_mean_q <= '0;
			res_std_q  <= '0;
			res_max_q  <= '0;
		end
		if (state_q == S_LOAD) begin
			neg_q     <= sum_rd_q[SB-1];
			res_max_q <= max_rd_q;
		end
		if (state_q == S_MUL) begin
			m2_q       <= qs * qs;
			res_mean_q <= mean_sat;
		end
		if ((state_q == S_SQRT) && sqrt_done) begin
			res_std_q <= (root > STD_LIMIT) ? STD_LIMIT[STB-1:0] : root[STB-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			ovf_q       <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (pop) begin
						unique case (head.kind)
							esp_pkg::OP_CLEAR: begin
								count_q <= '0;
								ovf_q   <= 1'b0;
							end
							esp_pkg::OP_READ: begin
								res_valid_q <= !first && head.in_range;
								state_q     <= (!first && head.in_range) ? S_LOAD : S_OUT;
							end
							default: begin
								if (active) begin
									state_q <= S_ACC;
								end else if (head.eow) begin
									if (count_q != WIN_LIMIT) begin
										count_q <= count_q + 1'b1;
									end else begin
										ovf_q <= 1'b1;
									end
								end
							end
						endcase
					end
				end
				S_ACC: begin
					// stores are written in this state, and the window count moves on an end mark
					if (eow_q) begin
						count_q <= count_q + 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_LOAD: state_q <= S_DIV;
				S_DIV: begin
					if (qs_done && qe_done) begin
						state_q <= S_MUL;
					end
				end
				S_MUL: state_q <= S_VAR;
				S_VAR: state_q <= S_SQRT;
				S_SQRT: begin
					if (sqrt_done) begin
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (results.ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign results.valid          = (state_q == S_OUT);
	assign results.mean_value     = res_mean_q;
	assign results.std_value      = res_std_q;
	assign results.max_value      = res_max_q;
	assign results.windows_seen   = res_seen_q;
	assign results.stats_valid    = res_valid_q;
	assign results.count_overflow = res_ovf_q;
endmodule

// ===== sim/esp_tb_channels.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// esp_tb_channels
// idle-pattern helper used by the pooling testbench
// ---------------------------------------------------------------------------
// the block's own interface file supplies esp_item_if, esp_cfg_if and
// esp_result_if; this file only holds a small idle-pattern helper
module esp_tb_stall_gen (
	input  logic clk,
	input  logic arst_n,
	output logic stall
);
	logic [7:0] cnt;
	logic [1:0] mode;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt   <= 8'd0;
			mode  <= 2'd0;
			stall <= 1'b0;
		end else if (cnt == 8'd0) begin
			mode  <= 2'($urandom_range(0, 3));
			cnt   <= 8'($urandom_range(4, 60));
			stall <= 1'b0;
		end else begin
			cnt <= cnt - 8'd1;
			case (mode)
				2'd0: stall <= 1'b0;
				2'd1: stall <= ($urandom_range(0, 3) == 0);
				2'd2: stall <= ($urandom_range(0, 1) == 0);
				default: stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end
endmodule

// ===== sim/embedding_stats_pooling_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// embedding_stats_pooling_tb
// drives words into the pooling block and checks every returned result
// against a local model of the per-feature sum, square sum and maximum
// ---------------------------------------------------------------------------
module embedding_stats_pooling_tb;
	localparam int VB   = esp_pkg::VALUE_BITS;
	localparam int STB  = esp_pkg::STD_BITS;
	localparam int SEB  = esp_pkg::SEEN_BITS;
	localparam int IB   = esp_pkg::INDEX_BITS;
	localparam int SUMB = esp_pkg::SUM_BITS;
	localparam int SQB  = esp_pkg::SQ_BITS;
	localparam int DB   = esp_pkg::DIM_BITS;

	localparam int NFEAT    = 2048;
	localparam int NWIN     = 255;
	localparam int CYC_MAX  = 3000000;
	localparam int SETTLE   = 200;

	typedef struct packed {
		logic signed [VB-1:0] mean;
		logic [STB-1:0]       sd;
		logic signed [VB-1:0] vmax;
		logic [SEB-1:0]       seen;
		logic                 ok;
		logic                 ovf;
	} stats_t;

	typedef struct {
		esp_pkg::op_t         kind;
		logic [IB-1:0]        idx;
		logic signed [VB-1:0] value;
		logic                 eow;
		logic                 fixed;
		stats_t               want;
	} row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic rx_stall;

	esp_cfg_if    cfg ();
	esp_item_if   items ();
	esp_result_if results ();

	embedding_stats_pooling u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.items  (items),
		.results(results)
	);

	esp_tb_stall_gen u_rx_stall (.clk(clk), .arst_n(arst_n), .stall(rx_stall));

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// model state
	logic [SUMB-1:0]      sum_mem [NFEAT];
	logic [SQB-1:0]       sq_mem  [NFEAT];
	logic signed [VB-1:0] max_mem [NFEAT];
	bit                   written [NFEAT];
	int unsigned          win_count;
	bit                   ovf_flag;
	int unsigned          dim_reg;

	stats_t pending_stats [$];
	bit     pending_fixed [$];
	stats_t fixed_want [$];
	int     errors = 0;
	longint cycle = 0;

	function automatic longint unsigned int_sqrt(longint unsigned x);
		longint unsigned r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic int unsigned live_limit();
		return dim_reg < NFEAT ? dim_reg : NFEAT;
	endfunction

	// fold one word into the model; returns 1 and the stats on a read
	function automatic bit pool_word(esp_pkg::op_t k, int unsigned ix,
		logic signed [VB-1:0] v, bit eow, output stats_t st);
		longint signed s, m, vmx;
		longint unsigned e2, am, var_q, sd, sq;
		st = '0;
		vmx = (64'sd1 <<< (VB - 1)) - 1;
		case (k)
			esp_pkg::OP_ACC: begin
				if (win_count < NWIN && ix < live_limit()) begin
					sq = longint'(v) * longint'(v);
					if (win_count == 0) begin
						sum_mem[ix] = SUMB'(longint'(v));
						sq_mem[ix]  = SQB'(sq);
						max_mem[ix] = v;
						written[ix] = 1'b1;
					end else begin
						sum_mem[ix] = sum_mem[ix] + SUMB'(longint'(v));
						sq_mem[ix]  = sq_mem[ix] + SQB'(sq);
						if (v > max_mem[ix]) max_mem[ix] = v;
					end
				end
				if (eow) begin
					if (win_count < NWIN) win_count++;
					else ovf_flag = 1'b1;
				end
				return 1'b0;
			end
			esp_pkg::OP_CLEAR: begin
				win_count = 0;
				ovf_flag = 1'b0;
				return 1'b0;
			end
			esp_pkg::OP_READ: begin
				if (win_count > 0 && ix < live_limit()) begin
					s = longint'($signed(sum_mem[ix]));
					m = s / longint'(win_count);
					e2 = longint'(sq_mem[ix]) / longint'(win_count);
					am = m < 0 ? -m : m;
					var_q = e2 > am * am ? e2 - am * am : 0;
					sd = int_sqrt(var_q);
					if (m > vmx) m = vmx;
					if (m < -vmx - 1) m = -vmx - 1;
					if (sd > vmx) sd = vmx;
					st.mean = VB'(m);
					st.sd   = STB'(sd);
					st.vmax = max_mem[ix];
					st.ok   = 1'b1;
				end
				st.seen = SEB'(win_count);
				st.ovf  = ovf_flag;
				return 1'b1;
			end
			default: return 1'b0;
		endcase
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		$display("mismatch %s: got %0d want %0d (cycle %0d)", what, got, want, cycle);
		errors++;
	endtask

	// sender idle pattern: bursts and gaps
	int burst_left;
	int gap_left;
	task automatic sender_pause();
		if (burst_left > 0) begin
			burst_left--;
			return;
		end
		gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
		if (gap_left > 0) begin
			items.valid <= 1'b0;
			repeat (gap_left) @(posedge clk);
		end
		burst_left = $urandom_range(1, 40);
	endtask

	// valid stays up after the accepting edge; the next word or a gap follows at once
	task automatic send_word(esp_pkg::op_t k, int unsigned ix, logic signed [VB-1:0] v,
		bit eow, bit fixed, stats_t want);
		stats_t st;
		bit got;
		sender_pause();
		items.valid         <= 1'b1;
		items.op            <= k;
		items.feat_index    <= IB'(ix);
		items.feat_value    <= v;
		items.end_of_window <= eow;
		@(posedge clk);
		while (!items.ready) @(posedge clk);
		got = pool_word(k, ix, v, eow, st);
		if (got) begin
			pending_stats.push_back(st);
			pending_fixed.push_back(fixed);
			if (fixed) fixed_want.push_back(want);
		end
	endtask

	task automatic drain();
		items.valid <= 1'b0;
		while (pending_stats.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_dim(int unsigned d);
		cfg.valid         <= 1'b1;
		cfg.used_features <= DB'(d);
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		cfg.valid <= 1'b0;
		dim_reg = d;
	endtask

	// result checking
	always @(posedge clk) begin
		stats_t e;
		stats_t f;
		bit fx;
		if (arst_n && results.valid && results.ready) begin
			if (pending_stats.size() == 0) begin
				$display("unexpected result word (cycle %0d)", cycle);
				errors++;
			end else begin
				e = pending_stats.pop_front();
				fx = pending_fixed.pop_front();
				if (fx) begin
					f = fixed_want.pop_front();
					if (f != e) report_mismatch("table row vs model", longint'(f), longint'(e));
				end
				if (results.mean_value != e.mean)
					report_mismatch("mean_value", results.mean_value, e.mean);
				if (results.std_value != e.sd)
					report_mismatch("std_value", results.std_value, e.sd);
				if (results.max_value != e.vmax)
					report_mismatch("max_value", results.max_value, e.vmax);
				if (results.windows_seen != e.seen)
					report_mismatch("windows_seen", results.windows_seen, e.seen);
				if (results.stats_valid != e.ok)
					report_mismatch("stats_valid", results.stats_valid, e.ok);
				if (results.count_overflow != e.ovf)
					report_mismatch("count_overflow", results.count_overflow, e.ovf);
			end
		end
	end

	always @(posedge clk) results.ready <= arst_n ? !rx_stall : 1'b0;

	always @(posedge clk) begin
		cycle <= cycle + 1;
		if (cycle > CYC_MAX) begin
			$display("Verification failed");
			$finish;
		end
	end

	// directed rows; fixed expectations only where obvious
	function automatic row_t mk(esp_pkg::op_t k, int ix, int v, bit e, bit fx, stats_t w);
		row_t r;
		r.kind = k; r.idx = IB'(ix); r.value = VB'(v);
		r.eow = e; r.fixed = fx; r.want = w;
		return r;
	endfunction

	// one clip: a clear, a first window that walks the indices below span, more windows, then reads
	task automatic run_clip(int nwin, int span, int reads);
		int unsigned lim;
		int unsigned ix;
		logic signed [VB-1:0] v;
		stats_t z;
		z = '0;
		lim = live_limit();
		send_word(esp_pkg::OP_CLEAR, $urandom_range(0, 2047), VB'($urandom),
			1'($urandom_range(0, 1)), 1'b0, z);
		for (int w = 0; w < nwin; w++) begin
			for (int i = 0; i < span; i++) begin
				// first window walks the indices below span; later ones random
				ix = (w == 0) ? i : $urandom_range(0, span - 1);
				if ($urandom_range(0, 19) == 0) ix = $urandom_range(0, 2047);
				case ($urandom_range(0, 3))
					0: v = VB'($urandom_range(0, 1) ? 24'h7fffff : 24'h800000);
					1: v = VB'(int'($urandom_range(0, 255)) - 128);
					default: v = VB'($urandom);
				endcase
				send_word(esp_pkg::OP_ACC, ix, v, i == span - 1, 1'b0, z);
			end
		end
		for (int r = 0; r < reads; r++) begin
			ix = $urandom_range(0, 7) == 0 ? $urandom_range(0, 2047) : $urandom_range(0, span - 1);
			// an unwritten live index is read at index 0 instead
			if (ix < lim && !written[ix]) ix = 0;
			send_word(esp_pkg::OP_READ, ix, VB'($urandom), 1'($urandom_range(0, 1)), 1'b0, z);
		end
		if ($urandom_range(0, 9) == 0)
			send_word(esp_pkg::op_t'(2'd3), $urandom_range(0, 2047), VB'($urandom), 1'b0,
				1'b0, z);
	endtask

	initial begin
		row_t tbl [$];
		stats_t z;
		stats_t w;
		int sent;
		burst_left = 0;
		dim_reg = esp_pkg::DIM_RESET;
		win_count = 0;
		ovf_flag = 1'b0;
		foreach (written[i]) written[i] = 1'b0;
		items.valid <= 1'b0;
		items.op <= esp_pkg::OP_ACC;
		items.feat_index <= '0;
		items.feat_value <= '0;
		items.end_of_window <= 1'b0;
		cfg.valid <= 1'b0;
		cfg.used_features <= esp_pkg::DIM_RESET;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		z = '0;
		// read before any window: invalid, count zero
		tbl.push_back(mk(esp_pkg::OP_READ, 0, 0, 0, 1, z));
		tbl.push_back(mk(esp_pkg::OP_ACC, 0, 24'h7fffff, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_ACC, 1, -8388608, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_ACC, 2, 0, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_ACC, 520, -1, 0, 0, z));
		// out of range index still counts its end mark
		tbl.push_back(mk(esp_pkg::OP_ACC, 2047, 5, 1, 0, z));
		w = '0; w.seen = 8'd1; w.ok = 1'b1; w.mean = 24'sh7fffff; w.vmax = 24'sh7fffff;
		tbl.push_back(mk(esp_pkg::OP_READ, 0, 0, 0, 1, w));
		w = '0; w.seen = 8'd1; w.ok = 1'b1; w.mean = 24'sh800000; w.vmax = 24'sh800000;
		tbl.push_back(mk(esp_pkg::OP_READ, 1, 0, 0, 1, w));
		tbl.push_back(mk(esp_pkg::OP_READ, 2, 0, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_READ, 520, 0, 1, 0, z));
		// out of range read
		w = '0; w.seen = 8'd1;
		tbl.push_back(mk(esp_pkg::OP_READ, 521, 0, 0, 1, w));
		tbl.push_back(mk(esp_pkg::OP_READ, 2047, 0, 0, 1, w));
		tbl.push_back(mk(esp_pkg::OP_ACC, 0, -8388608, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_ACC, 1, 24'h7fffff, 1, 0, z));
		tbl.push_back(mk(esp_pkg::OP_READ, 0, 0, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_READ, 1, 0, 0, 0, z));
		tbl.push_back(mk(esp_pkg::op_t'(2'd3), 5, 7, 1, 0, z));
		tbl.push_back(mk(esp_pkg::OP_CLEAR, 0, 0, 0, 0, z));
		tbl.push_back(mk(esp_pkg::OP_READ, 0, 0, 0, 1, z));
		foreach (tbl[i])
			send_word(tbl[i].kind, tbl[i].idx, tbl[i].value, tbl[i].eow, tbl[i].fixed,
				tbl[i].want);
		drain();

		// count saturation and overflow, with a narrow feature set
		write_dim(1);
		send_word(esp_pkg::OP_ACC, 0, 24'sd100, 1'b1, 1'b0, z);
		for (int i = 0; i < NWIN + 3; i++)
			send_word(esp_pkg::OP_ACC, 0, VB'($urandom), 1'b1, 1'b0, z);
		send_word(esp_pkg::OP_READ, 0, 0, 1'b0, 1'b0, z);
		send_word(esp_pkg::OP_READ, 1, 0, 1'b0, 1'b0, z);
		drain();

		// random clips under several feature sizes, the extremes among them
		sent = 0;
		for (int ph = 0; sent < 1300; ph++) begin
			case (ph % 5)
				0: write_dim(4095);
				1: write_dim(1);
				2: write_dim(2048);
				3: write_dim($urandom_range(2, 40));
				default: write_dim($urandom_range(1, 16));
			endcase
			for (int c = 0; c < 4; c++) begin
				int span;
				int nw;
				int rd;
				span = $urandom_range(1, live_limit() < 24 ? live_limit() : 24);
				nw = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60) : $urandom_range(1, 6);
				rd = $urandom_range(2, 8);
				run_clip(nw, span, rd);
				sent += nw * span + rd + 1;
			end
			drain();
		end

		drain();
		if (errors == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end
endmodule
